/* hdl/chsd_pkg.sv */
// Shared types, constants and codes for the context Huffman string decoder.
`default_nettype none
package chsd_pkg;

	localparam int NODE_COUNT      = 4096;
	localparam int MAX_CODE_LENGTH = 32;
	localparam int NODE_W          = $clog2(NODE_COUNT);
	localparam int FREE_W          = NODE_W + 1;
	localparam int CNT_W           = $clog2(MAX_CODE_LENGTH + 1);
	localparam int CODE_W          = 32;
	localparam int LEN_W           = 6;
	localparam int SYM_W           = 9;
	localparam int CHAR_W          = 8;
	localparam int BYTE_BITS       = 8;
	localparam int ESC_CNT_W       = $clog2(BYTE_BITS);
	localparam int KIND_W          = 3;
	localparam int OP_W            = 2;
	localparam int IN_DATA_W       = 64;
	localparam int OUT_DATA_W      = 8;
	localparam int OUT_USER_W      = 8;

	localparam logic [SYM_W-1:0] START_CTX  = 9'd256;
	localparam logic [SYM_W-1:0] SYM_START  = 9'd256;
	localparam logic [SYM_W-1:0] SYM_ESCAPE = 9'd258;
	localparam logic [FREE_W-1:0] FIRST_FREE = FREE_W'(int'(START_CTX) + 1);

	localparam logic [OP_W-1:0] OP_MAP    = 2'd0;
	localparam logic [OP_W-1:0] OP_START  = 2'd1;
	localparam logic [OP_W-1:0] OP_STREAM = 2'd2;

	localparam logic [KIND_W-1:0] KIND_CHAR   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_STOP   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ENDED  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_STORED = 3'd3;
	localparam logic [KIND_W-1:0] KIND_FULL   = 3'd4;

	typedef logic [NODE_W-1:0] node_t;

	typedef struct packed {
		logic             leaf;
		logic [SYM_W-1:0] value;
		node_t            kid1;
		node_t            kid0;
	} node_word_t;

	typedef enum logic [1:0] {
		MODE_FINISHED,
		MODE_HUFFMAN,
		MODE_ESCAPE
	} mode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_MAP,
		ST_DEC_CHK1,
		ST_DEC_CHK2
	} state_t;

	typedef enum logic [3:0] {
		DP_NONE,
		DP_CLEAR,
		DP_LOAD,
		DP_START,
		DP_MAP_INIT,
		DP_MAP_STEP,
		DP_DEC_END,
		DP_DEC_ESC,
		DP_DEC_READ,
		DP_DEC_STEP1,
		DP_DEC_STEP2
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic            clear_last;
		logic [OP_W-1:0] op;
		logic            bad_map;
		logic            mode_fin;
		logic            mode_esc;
		logic            data_end;
		logic            esc_emit;
		logic            map_emit;
		logic            child_zero;
		logic            dec2_emit;
		logic            out_free;
	} sts_t;

endpackage
`default_nettype wire

/* hdl/chsd_ctrl.sv */
// Controller state machine: sequences clearing, mapping walks and decode steps.
`default_nettype none
module chsd_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     s_tvalid,
	output logic                    s_tready,
	input  wire chsd_pkg::sts_t     sts,
	output chsd_pkg::cmd_t          cmd
);

	chsd_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chsd_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = chsd_pkg::DP_NONE;
		s_tready = 1'b0;
		unique case (state_q)
			chsd_pkg::ST_CLEAR: begin
				cmd.op = chsd_pkg::DP_CLEAR;
				if (sts.clear_last) state_d = chsd_pkg::ST_IDLE;
			end
			chsd_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op  = chsd_pkg::DP_LOAD;
					state_d = chsd_pkg::ST_EXEC;
				end
			end
			chsd_pkg::ST_EXEC: begin
				state_d = chsd_pkg::ST_IDLE;
				priority if (sts.op == chsd_pkg::OP_MAP) begin
					if (!sts.bad_map) begin
						cmd.op  = chsd_pkg::DP_MAP_INIT;
						state_d = chsd_pkg::ST_MAP;
					end
				end else if (sts.op == chsd_pkg::OP_START) begin
					cmd.op = chsd_pkg::DP_START;
				end else if (sts.op == chsd_pkg::OP_STREAM && !sts.mode_fin) begin
					priority if (sts.data_end) begin
						if (sts.out_free) cmd.op = chsd_pkg::DP_DEC_END;
						else state_d = chsd_pkg::ST_EXEC;
					end else if (sts.mode_esc) begin
						if (sts.out_free || !sts.esc_emit) cmd.op = chsd_pkg::DP_DEC_ESC;
						else state_d = chsd_pkg::ST_EXEC;
					end else begin
						cmd.op  = chsd_pkg::DP_DEC_READ;
						state_d = chsd_pkg::ST_DEC_CHK1;
					end
				end else begin
					cmd.op = chsd_pkg::DP_NONE;
				end
			end
			chsd_pkg::ST_MAP: begin
				if (sts.out_free || !sts.map_emit) begin
					cmd.op = chsd_pkg::DP_MAP_STEP;
					if (sts.map_emit) state_d = chsd_pkg::ST_IDLE;
				end
			end
			chsd_pkg::ST_DEC_CHK1: begin
				if (sts.out_free || !sts.child_zero) begin
					cmd.op  = chsd_pkg::DP_DEC_STEP1;
					state_d = sts.child_zero ? chsd_pkg::ST_IDLE : chsd_pkg::ST_DEC_CHK2;
				end
			end
			chsd_pkg::ST_DEC_CHK2: begin
				if (sts.out_free || !sts.dec2_emit) begin
					cmd.op  = chsd_pkg::DP_DEC_STEP2;
					state_d = chsd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = chsd_pkg::ST_CLEAR;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_clear_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == chsd_pkg::ST_CLEAR) |=> !(state_q == chsd_pkg::ST_EXEC))
		else $error("item taken during clearing pass");
	a_load_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == chsd_pkg::DP_LOAD) |=> (state_q == chsd_pkg::ST_EXEC))
		else $error("loaded item not executed");
	a_step2_after_step1: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == chsd_pkg::ST_DEC_CHK2)
		|-> (($past(cmd.op) == chsd_pkg::DP_DEC_STEP1)
		     || ($past(state_q) == chsd_pkg::ST_DEC_CHK2)))
		else $error("leaf check without child read");
`endif

endmodule
`default_nettype wire

/* hdl/chsd_dp.sv */
// Datapath: node store, tree walk registers, decode state and output register.
`default_nettype none
module chsd_dp (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire chsd_pkg::cmd_t               cmd,
	output chsd_pkg::sts_t                    sts,
	input  wire [chsd_pkg::IN_DATA_W-1:0]     s_tdata,
	input  wire [chsd_pkg::OP_W-1:0]          s_tuser,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [chsd_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic [chsd_pkg::OUT_USER_W-1:0]   m_tuser
);

	// Node store.
	chsd_pkg::node_word_t mem [chsd_pkg::NODE_COUNT];
	chsd_pkg::node_word_t rd_q;
	logic                 rd_en, wr_en;
	chsd_pkg::node_t      rd_addr, wr_addr;
	chsd_pkg::node_word_t wr_data;

	// Item registers.
	logic [chsd_pkg::OP_W-1:0]   op_q;
	logic [chsd_pkg::CODE_W-1:0] bits_q;
	logic [chsd_pkg::LEN_W-1:0]  len_q;
	logic [chsd_pkg::SYM_W-1:0]  ctx_q;
	logic [chsd_pkg::SYM_W-1:0]  sym_q;
	logic                        bit_q;
	logic                        end_q;

	// Walk and decode state.
	logic [chsd_pkg::MAX_CODE_LENGTH-1:0] code_q;
	logic [chsd_pkg::CNT_W-1:0]           cnt_q;
	chsd_pkg::node_t                      map_node_q;
	chsd_pkg::node_t                      nxt_q;
	chsd_pkg::node_t                      cur_node_q;
	logic [chsd_pkg::FREE_W-1:0]          next_free_q;
	chsd_pkg::node_t                      clr_addr_q;
	chsd_pkg::mode_t                      mode_q;
	logic [chsd_pkg::CHAR_W-1:0]          esc_byte_q;
	logic [chsd_pkg::ESC_CNT_W-1:0]       esc_cnt_q;

	// Output register.
	logic                          out_valid_q;
	logic [chsd_pkg::KIND_W-1:0]   out_kind_q;
	logic [chsd_pkg::CHAR_W-1:0]   out_char_q;

	logic                          emit;
	logic [chsd_pkg::KIND_W-1:0]   emit_kind;
	logic [chsd_pkg::CHAR_W-1:0]   emit_char;

	logic                          walk_bit;
	chsd_pkg::node_t               map_child, dec_child;
	logic                          store_full;
	logic [chsd_pkg::CHAR_W-1:0]   esc_next;
	logic [chsd_pkg::CNT_W-1:0]    len_cut;
	logic [chsd_pkg::MAX_CODE_LENGTH-1:0] code_init;

	always_comb begin
		walk_bit   = code_q[chsd_pkg::MAX_CODE_LENGTH-1];
		map_child  = walk_bit ? rd_q.kid1 : rd_q.kid0;
		dec_child  = bit_q ? rd_q.kid1 : rd_q.kid0;
		store_full = (next_free_q == chsd_pkg::FREE_W'(chsd_pkg::NODE_COUNT));
		esc_next   = {esc_byte_q[chsd_pkg::CHAR_W-2:0], bit_q};
		len_cut    = (32'(len_q) > 32'(chsd_pkg::MAX_CODE_LENGTH))
		             ? chsd_pkg::CNT_W'(chsd_pkg::MAX_CODE_LENGTH)
		             : chsd_pkg::CNT_W'(len_q);
		// Left-align the code so the oldest bit sits at the top of the walk register.
		code_init  = chsd_pkg::MAX_CODE_LENGTH'(bits_q)
		             << (chsd_pkg::CNT_W'(chsd_pkg::MAX_CODE_LENGTH) - len_cut);

		sts.clear_last = (clr_addr_q == chsd_pkg::node_t'(chsd_pkg::NODE_COUNT - 1));
		sts.op         = op_q;
		sts.bad_map    = (ctx_q > chsd_pkg::START_CTX) || (sym_q > chsd_pkg::SYM_ESCAPE);
		sts.mode_fin   = (mode_q == chsd_pkg::MODE_FINISHED);
		sts.mode_esc   = (mode_q == chsd_pkg::MODE_ESCAPE);
		sts.data_end   = end_q;
		sts.esc_emit   = (esc_cnt_q == chsd_pkg::ESC_CNT_W'(chsd_pkg::BYTE_BITS - 1));
		sts.map_emit   = (cnt_q == '0) || ((map_child == '0) && store_full);
		sts.child_zero = (dec_child == '0);
		sts.dec2_emit  = rd_q.leaf && (rd_q.value != chsd_pkg::SYM_START)
		                 && (rd_q.value != chsd_pkg::SYM_ESCAPE);
		sts.out_free   = !out_valid_q || m_tready;
	end

	// Memory port control and result generation.
	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = cur_node_q;
		wr_en     = 1'b0;
		wr_addr   = map_node_q;
		wr_data   = rd_q;
		emit      = 1'b0;
		emit_kind = chsd_pkg::KIND_CHAR;
		emit_char = '0;
		unique case (cmd.op)
			chsd_pkg::DP_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_addr_q;
				wr_data = '0;
			end
			chsd_pkg::DP_MAP_INIT: begin
				rd_en   = 1'b1;
				rd_addr = chsd_pkg::node_t'(ctx_q);
			end
			chsd_pkg::DP_MAP_STEP: begin
				priority if (cnt_q == '0) begin
					wr_en         = 1'b1;
					wr_data.leaf  = 1'b1;
					wr_data.value = sym_q;
					emit          = 1'b1;
					emit_kind     = chsd_pkg::KIND_STORED;
				end else if (map_child != '0) begin
					rd_en   = 1'b1;
					rd_addr = map_child;
				end else if (store_full) begin
					emit      = 1'b1;
					emit_kind = chsd_pkg::KIND_FULL;
				end else begin
					// Link a fresh node to the parent and read it in the same cycle.
					wr_en   = 1'b1;
					if (walk_bit) wr_data.kid1 = next_free_q[chsd_pkg::NODE_W-1:0];
					else wr_data.kid0 = next_free_q[chsd_pkg::NODE_W-1:0];
					rd_en   = 1'b1;
					rd_addr = next_free_q[chsd_pkg::NODE_W-1:0];
				end
			end
			chsd_pkg::DP_DEC_END: begin
				emit      = 1'b1;
				emit_kind = chsd_pkg::KIND_ENDED;
			end
			chsd_pkg::DP_DEC_ESC: begin
				emit      = sts.esc_emit;
				emit_kind = chsd_pkg::KIND_CHAR;
				emit_char = esc_next;
			end
			chsd_pkg::DP_DEC_READ: begin
				rd_en   = 1'b1;
				rd_addr = cur_node_q;
			end
			chsd_pkg::DP_DEC_STEP1: begin
				if (dec_child == '0) begin
					emit      = 1'b1;
					emit_kind = chsd_pkg::KIND_ENDED;
				end else begin
					rd_en   = 1'b1;
					rd_addr = dec_child;
				end
			end
			chsd_pkg::DP_DEC_STEP2: begin
				emit = sts.dec2_emit;
				if (rd_q.value < chsd_pkg::SYM_START) begin
					emit_kind = chsd_pkg::KIND_CHAR;
					emit_char = rd_q.value[chsd_pkg::CHAR_W-1:0];
				end else begin
					emit_kind = chsd_pkg::KIND_STOP;
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	// Item payload and walk registers.
	always_ff @(posedge clk) begin
		if (cmd.op == chsd_pkg::DP_LOAD) begin
			op_q   <= s_tuser;
			bits_q <= s_tdata[31:0];
			len_q  <= s_tdata[37:32];
			ctx_q  <= s_tdata[46:38];
			sym_q  <= s_tdata[55:47];
			bit_q  <= s_tdata[56];
			end_q  <= s_tdata[57];
		end
		if (cmd.op == chsd_pkg::DP_MAP_INIT) begin
			code_q     <= code_init;
			cnt_q      <= len_cut;
			map_node_q <= chsd_pkg::node_t'(ctx_q);
		end
		if (cmd.op == chsd_pkg::DP_MAP_STEP && cnt_q != '0) begin
			code_q <= code_q << 1;
			cnt_q  <= cnt_q - 1'b1;
			if (map_child != '0) map_node_q <= map_child;
			else map_node_q <= next_free_q[chsd_pkg::NODE_W-1:0];
		end
		if (cmd.op == chsd_pkg::DP_DEC_STEP1) nxt_q <= dec_child;
		if (emit) begin
			out_kind_q <= emit_kind;
			out_char_q <= emit_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			next_free_q <= chsd_pkg::FIRST_FREE;
			cur_node_q  <= chsd_pkg::node_t'(chsd_pkg::START_CTX);
			mode_q      <= chsd_pkg::MODE_FINISHED;
			esc_byte_q  <= '0;
			esc_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			unique case (cmd.op)
				chsd_pkg::DP_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
				chsd_pkg::DP_START: begin
					mode_q     <= chsd_pkg::MODE_HUFFMAN;
					cur_node_q <= chsd_pkg::node_t'(chsd_pkg::START_CTX);
					esc_byte_q <= '0;
					esc_cnt_q  <= '0;
				end
				chsd_pkg::DP_MAP_STEP: begin
					if (cnt_q != '0 && map_child == '0 && !store_full)
						next_free_q <= next_free_q + 1'b1;
				end
				chsd_pkg::DP_DEC_END: begin
					mode_q     <= chsd_pkg::MODE_FINISHED;
					esc_byte_q <= '0;
					esc_cnt_q  <= '0;
				end
				chsd_pkg::DP_DEC_ESC: begin
					if (sts.esc_emit) begin
						esc_byte_q <= '0;
						esc_cnt_q  <= '0;
						// A byte with the top bit clear resumes coded text in its context.
						if (!esc_next[chsd_pkg::CHAR_W-1]) begin
							mode_q     <= chsd_pkg::MODE_HUFFMAN;
							cur_node_q <= chsd_pkg::node_t'(esc_next);
						end
					end else begin
						esc_byte_q <= esc_next;
						esc_cnt_q  <= esc_cnt_q + 1'b1;
					end
				end
				chsd_pkg::DP_DEC_STEP1: begin
					if (dec_child == '0) mode_q <= chsd_pkg::MODE_FINISHED;
				end
				chsd_pkg::DP_DEC_STEP2: begin
					priority if (!rd_q.leaf) begin
						cur_node_q <= nxt_q;
					end else if (rd_q.value < chsd_pkg::SYM_START) begin
						cur_node_q <= chsd_pkg::node_t'(rd_q.value);
					end else if (rd_q.value == chsd_pkg::SYM_START) begin
						cur_node_q <= chsd_pkg::node_t'(chsd_pkg::START_CTX);
					end else if (rd_q.value == chsd_pkg::SYM_ESCAPE) begin
						mode_q     <= chsd_pkg::MODE_ESCAPE;
						esc_byte_q <= '0;
						esc_cnt_q  <= '0;
					end else begin
						mode_q <= chsd_pkg::MODE_FINISHED;
					end
				end
				default: begin
					clr_addr_q <= clr_addr_q;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tuser  = chsd_pkg::OUT_USER_W'(out_kind_q);

`ifndef ASSERT_OFF
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q <= chsd_pkg::FREE_W'(chsd_pkg::NODE_COUNT))
		else $error("free pointer beyond node store");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && out_valid_q) |-> m_tready)
		else $error("result written over a pending beat");
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == chsd_pkg::DP_MAP_STEP)
		|-> (32'(cnt_q) <= 32'(chsd_pkg::MAX_CODE_LENGTH)))
		else $error("walk count beyond code length");
	a_alloc_step: assert property (@(posedge clk) disable iff (!arst_n)
		(next_free_q != $past(next_free_q)) |-> ($past(cmd.op) == chsd_pkg::DP_MAP_STEP))
		else $error("node allocated outside a mapping walk");
`endif

endmodule
`default_nettype wire

/* hdl/context_huffman_string_decoder.sv */
// Top level of the order-1 context Huffman string decoder.
//
// After reset the block sweeps its 4096-entry node store, one entry a cycle, so
// no input beat is taken until the sweep ends. Input beats carry the operation
// in tuser; each result beat carries its kind in tuser and a character in
// tdata. A coded stream bit passes the execute state and the check states
// before the next ready (two serial node-store reads: the current node,
// then its child); a start beat, an escape bit or an end of data passes only
// the execute state; an add-mapping beat takes one walk step per code bit, as
// the node store has a single read port. A result waiting at the output does
// not hold off the next input beat unless that beat has its own result to give.
`default_nettype none
module context_huffman_string_decoder (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_tvalid,
	output logic                            s_tready,
	// code_bits[31:0], code_length[37:32], context_req[46:38], symbol[55:47],
	// stream_bit[56], data_end[57], zero[63:58]
	input  wire [chsd_pkg::IN_DATA_W-1:0]   s_tdata,
	// operation[1:0]
	input  wire [chsd_pkg::OP_W-1:0]        s_tuser,
	output logic                            m_tvalid,
	input  wire                             m_tready,
	// character[7:0]
	output logic [chsd_pkg::OUT_DATA_W-1:0] m_tdata,
	// result_kind[2:0], zero[7:3]
	output logic [chsd_pkg::OUT_USER_W-1:0] m_tuser
);

	chsd_pkg::cmd_t cmd;
	chsd_pkg::sts_t sts;

	chsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	chsd_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire

/* bench/tb_context_huffman_string_decoder.sv */
// Self-checking testbench for the order-1 context Huffman string decoder.
module tb_context_huffman_string_decoder;
	import chsd_pkg::*;

	localparam logic [SYM_W-1:0] SYM_STOP = 9'd257;
	// Marks a code deliberately left out of a tree, so that it walks into a missing branch.
	localparam logic [SYM_W-1:0] NO_LEAF = 9'h1FF;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam logic [CHAR_W-1:0] TOP_BIT = 8'h80;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 64;
	localparam int MAX_CODES = 16;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [CODE_W-1:0] bits;
		logic [LEN_W-1:0]  len;
		logic [SYM_W-1:0]  ctx;
		logic [SYM_W-1:0]  sym;
		logic              sbit;
		logic              dend;
	} coded_item_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CHAR_W-1:0] ch;
	} decoded_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [OP_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;

	context_huffman_string_decoder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Decoder state as the testbench sees it.
	node_t kid0_of [NODE_COUNT];
	node_t kid1_of [NODE_COUNT];
	logic is_leaf [NODE_COUNT];
	logic [SYM_W-1:0] leaf_sym [NODE_COUNT];
	logic [FREE_W-1:0] free_node;
	node_t walk_node;
	mode_t dec_mode;
	logic [CHAR_W-1:0] esc_byte;
	int esc_count;

	coded_item_t coded_stream [$];
	decoded_t due_decodes [$];

	// Codes known to the stimulus side, per context, so strings can be well formed.
	logic [CODE_W-1:0] code_word [START_CTX+1][MAX_CODES];
	int code_size [START_CTX+1][MAX_CODES];
	logic [SYM_W-1:0] code_sym [START_CTX+1][MAX_CODES];
	int code_total [START_CTX+1];
	logic [CHAR_W-1:0] alpha [6];
	logic [CHAR_W-1:0] low_alpha [$];

	coded_item_t offered;
	int total_items = 0;
	int items_taken = 0;
	int results_seen = 0;
	int failures = 0;
	int send_idle = 0;
	int send_burst = 0;
	int recv_idle = 0;
	int recv_burst = 0;
	int hold_left = 0;
	int next_hold_at = 40;

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

	task automatic append_item(input coded_item_t it);
		coded_stream = {coded_stream, it};
	endtask

	task automatic emit_decode(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] ch);
		decoded_t r;
		r.kind = kind;
		r.ch = ch;
		due_decodes = {due_decodes, r};
	endtask

	task automatic decode_item(input coded_item_t it);
		int n, k;
		node_t nd, nx;
		bit stuck;
		case (it.op)
			OP_MAP: if (it.ctx <= START_CTX && it.sym <= SYM_ESCAPE) begin
				n = (it.len > MAX_CODE_LENGTH) ? MAX_CODE_LENGTH : int'(it.len);
				nd = node_t'(it.ctx);
				stuck = 1'b0;
				for (k = n; k > 0 && !stuck; k--) begin
					nx = it.bits[k-1] ? kid1_of[nd] : kid0_of[nd];
					if (nx == '0) begin
						if (free_node >= NODE_COUNT) begin
							stuck = 1'b1;
						end else begin
							nx = node_t'(free_node);
							free_node++;
							if (it.bits[k-1])
								kid1_of[nd] = nx;
							else
								kid0_of[nd] = nx;
						end
					end
					if (!stuck)
						nd = nx;
				end
				if (stuck) begin
					emit_decode(KIND_FULL, '0);
				end else begin
					is_leaf[nd] = 1'b1;
					leaf_sym[nd] = it.sym;
					emit_decode(KIND_STORED, '0);
				end
			end
			OP_START: begin
				dec_mode = MODE_HUFFMAN;
				walk_node = node_t'(START_CTX);
				esc_byte = '0;
				esc_count = 0;
			end
			OP_STREAM: if (dec_mode != MODE_FINISHED) begin
				if (it.dend) begin
					dec_mode = MODE_FINISHED;
					esc_byte = '0;
					esc_count = 0;
					emit_decode(KIND_ENDED, '0);
				end else if (dec_mode == MODE_ESCAPE) begin
					esc_byte = {esc_byte[CHAR_W-2:0], it.sbit};
					esc_count++;
					if (esc_count == BYTE_BITS) begin
						// A raw byte with the top bit clear leaves escape mode.
						if ((esc_byte & TOP_BIT) == '0) begin
							dec_mode = MODE_HUFFMAN;
							walk_node = node_t'(esc_byte);
						end
						emit_decode(KIND_CHAR, esc_byte);
						esc_byte = '0;
						esc_count = 0;
					end
				end else begin
					nx = it.sbit ? kid1_of[walk_node] : kid0_of[walk_node];
					if (nx == '0) begin
						dec_mode = MODE_FINISHED;
						emit_decode(KIND_ENDED, '0);
					end else if (!is_leaf[nx]) begin
						walk_node = nx;
					end else if (leaf_sym[nx] < SYM_START) begin
						walk_node = node_t'(leaf_sym[nx]);
						emit_decode(KIND_CHAR, CHAR_W'(leaf_sym[nx]));
					end else if (leaf_sym[nx] == SYM_START) begin
						walk_node = node_t'(START_CTX);
					end else if (leaf_sym[nx] == SYM_ESCAPE) begin
						dec_mode = MODE_ESCAPE;
						esc_byte = '0;
						esc_count = 0;
					end else begin
						dec_mode = MODE_FINISHED;
						emit_decode(KIND_STOP, '0);
					end
				end
			end
			default: ;
		endcase
	endtask

	function automatic int idle_len(inout int burst);
		int r;
		if (burst > 0) begin
			burst--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			burst = $urandom_range(20, 60);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Fields that the operation does not use carry random values.
	function automatic coded_item_t scrambled(input logic [OP_W-1:0] op);
		coded_item_t it;
		it.op = op;
		it.bits = $urandom;
		it.len = LEN_W'($urandom_range(0, 63));
		it.ctx = SYM_W'($urandom_range(0, 511));
		it.sym = SYM_W'($urandom_range(0, 511));
		it.sbit = 1'($urandom_range(0, 1));
		it.dend = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic logic [SYM_W-1:0] pick_symbol();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return SYM_W'(alpha[$urandom_range(0, 5)]);
		if (r < 82)
			return SYM_STOP;
		if (r < 92)
			return SYM_ESCAPE;
		return SYM_START;
	endfunction

	task automatic note_code(input logic [SYM_W-1:0] ctx, input logic [CODE_W-1:0] val,
			input int n, input logic [SYM_W-1:0] s);
		int k;
		for (k = 0; k < code_total[ctx]; k++) begin
			if (code_size[ctx][k] == n && code_word[ctx][k] == val) begin
				code_sym[ctx][k] = s;
				return;
			end
		end
		if (code_total[ctx] < MAX_CODES) begin
			code_word[ctx][code_total[ctx]] = val;
			code_size[ctx][code_total[ctx]] = n;
			code_sym[ctx][code_total[ctx]] = s;
			code_total[ctx]++;
		end
	endtask

	task automatic add_code(input logic [SYM_W-1:0] ctx, input logic [CODE_W-1:0] val,
			input int n, input logic [SYM_W-1:0] s, input bit remember);
		coded_item_t it;
		it = scrambled(OP_MAP);
		it.ctx = ctx;
		it.sym = s;
		it.len = LEN_W'(n);
		if (n < CODE_W)
			it.bits = (it.bits << n) | (val & ((32'd1 << n) - 32'd1));
		else
			it.bits = val;
		append_item(it);
		if (remember)
			note_code(ctx, val, n, s);
	endtask

	task automatic push_bits(input logic [CODE_W-1:0] val, input int n);
		coded_item_t it;
		int k;
		for (k = n - 1; k >= 0; k--) begin
			it = scrambled(OP_STREAM);
			it.sbit = val[k];
			it.dend = 1'b0;
			append_item(it);
		end
	endtask

	task automatic stream_end();
		coded_item_t it;
		it = scrambled(OP_STREAM);
		it.dend = 1'b1;
		append_item(it);
	endtask

	// One string walked along known codes from the start tree until it stops or runs out.
	task automatic queue_string();
		logic [SYM_W-1:0] at, s;
		logic [CHAR_W-1:0] c;
		int steps, e, j;
		bit live;
		append_item(scrambled(OP_START));
		at = START_CTX;
		live = 1'b1;
		steps = 0;
		while (live) begin
			if (steps == 24 || $urandom_range(0, 39) == 0) begin
				stream_end();
				live = 1'b0;
			end else if (code_total[at] == 0) begin
				push_bits($urandom, 1);
				live = 1'b0;
			end else begin
				e = $urandom_range(0, code_total[at] - 1);
				push_bits(code_word[at][e], code_size[at][e]);
				s = code_sym[at][e];
				if (s == NO_LEAF || s == SYM_STOP) begin
					live = 1'b0;
				end else if (s == SYM_START) begin
					at = START_CTX;
				end else if (s == SYM_ESCAPE) begin
					for (j = $urandom_range(0, 2); j > 0; j--)
						push_bits($urandom | TOP_BIT, BYTE_BITS);
					if ($urandom_range(0, 9) == 0) begin
						push_bits($urandom, $urandom_range(1, 7));
						stream_end();
						live = 1'b0;
					end else begin
						if ($urandom_range(0, 5) == 0)
							c = CHAR_W'($urandom_range(0, 127));
						else
							c = low_alpha[$urandom_range(0, low_alpha.size() - 1)];
						push_bits(CODE_W'(c), BYTE_BITS);
						at = SYM_W'(c);
					end
				end else begin
					at = s;
				end
			end
			steps++;
			// Occasionally a new tree grows while a string is being decoded.
			if (live && $urandom_range(0, 29) == 0)
				add_code(SYM_W'($urandom_range(0, 255)), $urandom, $urandom_range(4, 12),
					SYM_W'($urandom_range(0, 258)), 1'b0);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				decode_item(offered);
				items_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_idle > 0) begin
					send_idle--;
					s_tvalid <= 1'b0;
				end else if (coded_stream.size() != 0) begin
					offered = coded_stream.pop_front();
					s_tdata <= {6'b0, offered.dend, offered.sbit, offered.sym, offered.ctx,
						offered.len, offered.bits};
					s_tuser <= offered.op;
					s_tvalid <= 1'b1;
					send_idle = idle_len(send_burst);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		decoded_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (due_decodes.size() == 0) begin
					$display("%0t: beat with nothing due, expected none, got kind %0d char %02h",
						$time, m_tuser, m_tdata);
					failures++;
				end else begin
					want = due_decodes.pop_front();
					if (m_tuser !== OUT_USER_W'(want.kind) || m_tdata !== want.ch) begin
						$display("%0t: expected kind %0d char %02h, got kind %0d char %02h",
							$time, want.kind, want.ch, m_tuser, m_tdata);
						failures++;
					end
				end
				recv_idle = idle_len(recv_burst);
			end
			// Now and then stop taking results long enough for the decoder to back up.
			if (results_seen >= next_hold_at) begin
				hold_left = HOLD_CYCLES;
				next_hold_at += 250;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (recv_idle > 0) begin
				recv_idle--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		coded_item_t it;
		int i, d, e;
		logic [SYM_W-1:0] at;
		logic [CHAR_W-1:0] c;
		bit used_char [256];

		for (i = 0; i < NODE_COUNT; i++) begin
			kid0_of[i] = '0;
			kid1_of[i] = '0;
			is_leaf[i] = 1'b0;
			leaf_sym[i] = '0;
		end
		free_node = FIRST_FREE;
		walk_node = node_t'(START_CTX);
		dec_mode = MODE_FINISHED;
		esc_byte = '0;
		esc_count = 0;
		for (i = 0; i <= START_CTX; i++)
			code_total[i] = 0;

		// Contexts 0 and 255 are kept for the directed long codes.
		alpha[0] = 8'h61;
		used_char[8'h61] = 1'b1;
		for (i = 1; i < 6; i++) begin
			do
				c = CHAR_W'($urandom_range(1, 254));
			while (used_char[c]);
			used_char[c] = 1'b1;
			alpha[i] = c;
		end
		for (i = 0; i < 6; i++)
			if ((alpha[i] & TOP_BIT) == '0)
				low_alpha = {low_alpha, alpha[i]};

		// Directed part. A stream bit before any start is ignored, as is the unused operation.
		append_item(scrambled(OP_STREAM));
		append_item(scrambled(OP_UNUSED));
		add_code(START_CTX, 32'b00, 2, SYM_W'(alpha[0]), 1'b1);
		add_code(START_CTX, 32'b01, 2, SYM_ESCAPE, 1'b1);
		add_code(START_CTX, 32'b10, 2, SYM_STOP, 1'b1);
		add_code(START_CTX, 32'b110, 3, SYM_START, 1'b1);
		note_code(START_CTX, 32'b111, 3, NO_LEAF);
		// A code running on through an existing leaf can never be decoded.
		add_code(START_CTX, 32'b000, 3, 9'd0, 1'b0);
		// An empty code turns the root itself into a leaf.
		add_code(SYM_W'(alpha[0]), 32'd0, 0, SYM_ESCAPE, 1'b0);
		// Code lengths beyond the maximum are cut back to it.
		add_code(9'd255, 32'hFFFF_FFFF, 63, 9'd0, 1'b0);
		add_code(9'd0, 32'd0, 32, 9'd255, 1'b0);
		it = scrambled(OP_MAP);
		it.ctx = 9'h1FF;
		it.sym = SYM_W'($urandom_range(0, 258));
		append_item(it);
		it = scrambled(OP_MAP);
		it.ctx = SYM_W'($urandom_range(0, 256));
		it.sym = 9'h1FF;
		append_item(it);
		// Character, then the empty tree of that character ends the string.
		append_item(scrambled(OP_START));
		push_bits(32'b00, 2);
		push_bits(32'b1, 1);
		// Start leaf returns to the start tree, then stop.
		append_item(scrambled(OP_START));
		push_bits(32'b110, 3);
		push_bits(32'b10, 2);
		// End of data in the middle of an escaped byte.
		append_item(scrambled(OP_START));
		push_bits(32'b01, 2);
		push_bits(32'b10, 2);
		stream_end();

		// Random trees for the character contexts, some codes left out.
		for (i = 0; i < 6; i++) begin
			d = $urandom_range(1, 3);
			for (e = 0; e < (1 << d); e++) begin
				if ($urandom_range(0, 7) == 0)
					note_code(SYM_W'(alpha[i]), CODE_W'(e), d, NO_LEAF);
				else
					add_code(SYM_W'(alpha[i]), CODE_W'(e), d, pick_symbol(), 1'b1);
			end
		end

		while (coded_stream.size() < 560) begin
			d = $urandom_range(0, 99);
			if (d < 78) begin
				queue_string();
			end else if (d < 88) begin
				at = ($urandom_range(0, 5) == 0) ? START_CTX : SYM_W'(alpha[$urandom_range(0, 5)]);
				if (code_total[at] != 0) begin
					e = $urandom_range(0, code_total[at] - 1);
					add_code(at, code_word[at][e], code_size[at][e], pick_symbol(), 1'b1);
				end
			end else begin
				case ($urandom_range(0, 2))
					0: append_item(scrambled(OP_UNUSED));
					1: begin
						it = scrambled(OP_MAP);
						if ($urandom_range(0, 1) == 0)
							it.ctx = SYM_W'($urandom_range(257, 511));
						else
							it.sym = SYM_W'($urandom_range(259, 511));
						append_item(it);
					end
					default: append_item(scrambled(OP_STREAM));
				endcase
			end
		end

		// Long codes until the node store runs out, then decode on a full store.
		for (i = 0; i < 160; i++)
			add_code(SYM_W'($urandom_range(0, 256)), $urandom,
				(i % 8 == 0) ? $urandom_range(33, 63) : 32, SYM_W'($urandom_range(0, 258)), 1'b0);
		for (i = 0; i < 3; i++)
			queue_string();
		total_items = coded_stream.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (items_taken != total_items)
			@(posedge clk);
		while (due_decodes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
